@@ design/bmtt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmtt_pkg
// Shared types, character codes and event codes for the brush-map tokenizer.
// ----------------------------------------------------------------------------
package bmtt_pkg;

    // Parser phase at the top level of the map grammar
    typedef enum logic [3:0] {
        PH_OUT_ENTITY     = 4'd0,
        PH_PROP_OR_BRUSH  = 4'd1,
        PH_KEY            = 4'd2,
        PH_EXPECT_VALUE   = 4'd3,
        PH_VALUE          = 4'd4,
        PH_BRUSH          = 4'd5,
        PH_POINTS         = 4'd6,
        PH_EXPECT_TEXTURE = 4'd7,
        PH_TEXTURE        = 4'd8,
        PH_EXPECT_U       = 4'd9,
        PH_U              = 4'd10,
        PH_EXPECT_V       = 4'd11,
        PH_V              = 4'd12,
        PH_ROTATION       = 4'd13,
        PH_USCALE         = 4'd14,
        PH_VSCALE         = 4'd15
    } main_phase_t;

    typedef enum logic [3:0] {
        EV_ENTITY_OPEN  = 4'd0,
        EV_ENTITY_CLOSE = 4'd1,
        EV_KEY_BYTE     = 4'd2,
        EV_KEY_END      = 4'd3,
        EV_VALUE_BYTE   = 4'd4,
        EV_VALUE_END    = 4'd5,
        EV_BRUSH_OPEN   = 4'd6,
        EV_BRUSH_CLOSE  = 4'd7,
        EV_PLANE_OPEN   = 4'd8,
        EV_NUM_BYTE     = 4'd9,
        EV_NUM_END      = 4'd10,
        EV_TEX_BYTE     = 4'd11,
        EV_TEX_END      = 4'd12,
        EV_ERROR        = 4'd13
    } event_kind_t;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_TEXTURE    = 2'd2;

    // Point sequencing: doing point 1, expect 2, doing 2, expect 3, doing 3
    localparam logic [2:0] PT_OUTSIDE = 3'd0;
    localparam logic [2:0] PT_DO1     = 3'd1;
    localparam logic [2:0] PT_EXP2    = 3'd2;
    localparam logic [2:0] PT_DO2     = 3'd3;
    localparam logic [2:0] PT_EXP3    = 3'd4;
    localparam logic [2:0] PT_DO3     = 3'd5;

    localparam logic [1:0] CO_OUTSIDE = 2'd0;
    localparam logic [1:0] CO_X       = 2'd1;
    localparam logic [1:0] CO_Z       = 2'd3;

    localparam logic [2:0] AX_OUTSIDE = 3'd0;
    localparam logic [2:0] AX_X       = 3'd1;
    localparam logic [2:0] AX_SHIFT   = 3'd4;

    localparam logic [4:0] FLD_U_BASE   = 5'd9;
    localparam logic [4:0] FLD_V_BASE   = 5'd13;
    localparam logic [4:0] FLD_ROTATION = 5'd17;
    localparam logic [4:0] FLD_USCALE   = 5'd18;
    localparam logic [4:0] FLD_VSCALE   = 5'd19;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        main_phase_t main_phase;
        logic [2:0]  point_phase;
        logic [1:0]  coord_phase;
        logic [2:0]  axis_phase;
        logic        token_started;
        logic [1:0]  rotation_len;
        logic        rotation_first_zero;
        logic        halted;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        event_kind_t kind;
        logic [4:0]  field;
        logic [7:0]  ch;
        logic        rot_nonzero;
        logic [1:0]  err;
    } token_event_t;

    function automatic logic texture_char_ok(input logic [7:0] c);
        logic ok;
        ok = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
             (c >= 8'd48 && c <= 8'd57) || c == 8'h2D || c == 8'h2B ||
             c == 8'h7E || c == 8'h5F || c == 8'h21 || c == CH_LBRACE ||
             c == 8'h23;
        return ok;
    endfunction

endpackage

@@ design/bmtt_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmtt_step
// Next-state and event logic for one character of map text.
// ----------------------------------------------------------------------------
module bmtt_step (
    input  bmtt_pkg::parse_state_t state,
    input  logic [7:0]             c,
    output bmtt_pkg::parse_state_t state_next,
    output bmtt_pkg::token_event_t ev
);
    import bmtt_pkg::*;

    logic       eol;
    logic [4:0] pt_base;
    logic [4:0] pt_field;
    logic [4:0] ax_base;
    logic [4:0] ax_field;
    logic       ax_in_group;

    assign eol = (c == CH_LF) || (c == CH_CR);

    // First field of the current point
    always_comb
    begin
        case (state.point_phase)
            PT_DO2:  pt_base = 5'd3;
            PT_DO3:  pt_base = 5'd6;
            default: pt_base = 5'd0;
        endcase
    end

    assign pt_field    = pt_base + {3'b000, state.coord_phase} - 5'd1;
    assign ax_base     = (state.main_phase == PH_V) ? FLD_V_BASE : FLD_U_BASE;
    assign ax_field    = ax_base + {2'b00, state.axis_phase} - 5'd1;
    assign ax_in_group = (state.axis_phase >= AX_X) && (state.axis_phase <= AX_SHIFT);

    always_comb
    begin
        state_next = state;
        ev         = '0;
        ev.kind    = EV_ENTITY_OPEN;

        if (!state.halted)
        begin
            case (state.main_phase)
                PH_OUT_ENTITY:
                begin
                    if (eol)
                    begin
                    end
                    else if (c == CH_LBRACE)
                    begin
                        state_next.main_phase = PH_PROP_OR_BRUSH;
                        ev.emit = 1'b1; ev.kind = EV_ENTITY_OPEN;
                    end
                    else
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                    end
                end
                PH_PROP_OR_BRUSH:
                begin
                    if (eol)
                    begin
                    end
                    else if (c == CH_QUOTE)
                        state_next.main_phase = PH_KEY;
                    else if (c == CH_LBRACE)
                    begin
                        state_next.main_phase = PH_BRUSH;
                        ev.emit = 1'b1; ev.kind = EV_BRUSH_OPEN;
                    end
                    else if (c == CH_RBRACE)
                    begin
                        state_next.main_phase = PH_OUT_ENTITY;
                        ev.emit = 1'b1; ev.kind = EV_ENTITY_CLOSE;
                    end
                    else
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                    end
                end
                PH_KEY:
                begin
                    ev.emit = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        state_next.main_phase = PH_EXPECT_VALUE;
                        ev.kind = EV_KEY_END;
                    end
                    else
                    begin
                        ev.kind = EV_KEY_BYTE; ev.ch = c;
                    end
                end
                PH_EXPECT_VALUE:
                begin
                    if (c == CH_QUOTE)
                        state_next.main_phase = PH_VALUE;
                    else if (c != CH_SPACE)
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                    end
                end
                PH_VALUE:
                begin
                    ev.emit = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        state_next.main_phase = PH_PROP_OR_BRUSH;
                        ev.kind = EV_VALUE_END;
                    end
                    else
                    begin
                        ev.kind = EV_VALUE_BYTE; ev.ch = c;
                    end
                end
                PH_BRUSH:
                begin
                    if (eol)
                    begin
                    end
                    else if (c == CH_RBRACE)
                    begin
                        state_next.main_phase = PH_PROP_OR_BRUSH;
                        ev.emit = 1'b1; ev.kind = EV_BRUSH_CLOSE;
                    end
                    else if (c == CH_LPAREN)
                    begin
                        state_next.main_phase    = PH_POINTS;
                        state_next.point_phase   = PT_DO1;
                        state_next.coord_phase   = CO_X;
                        state_next.token_started = 1'b0;
                        ev.emit = 1'b1; ev.kind = EV_PLANE_OPEN;
                    end
                    else
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                    end
                end
                PH_POINTS:
                begin
                    if (state.point_phase == PT_EXP2 || state.point_phase == PT_EXP3)
                    begin
                        if (c == CH_RPAREN || c == CH_SPACE)
                        begin
                        end
                        else if (c == CH_LPAREN)
                        begin
                            state_next.point_phase   = state.point_phase + 3'd1;
                            state_next.coord_phase   = CO_X;
                            state_next.token_started = 1'b0;
                        end
                        else
                        begin
                            state_next.halted = 1'b1;
                            ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                        end
                    end
                    else if ((state.point_phase != PT_DO1 && state.point_phase != PT_DO2 &&
                              state.point_phase != PT_DO3) ||
                             state.coord_phase == CO_OUTSIDE)
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                    end
                    else if (c != CH_SPACE)
                    begin
                        state_next.token_started = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_NUM_BYTE; ev.field = pt_field; ev.ch = c;
                    end
                    else if (state.token_started)
                    begin
                        state_next.token_started = 1'b0;
                        ev.emit = 1'b1; ev.kind = EV_NUM_END; ev.field = pt_field;
                        if (state.coord_phase != CO_Z)
                            state_next.coord_phase = state.coord_phase + 2'd1;
                        else
                        begin
                            state_next.coord_phase = CO_OUTSIDE;
                            if (state.point_phase == PT_DO3)
                            begin
                                state_next.point_phase = PT_OUTSIDE;
                                state_next.main_phase  = PH_EXPECT_TEXTURE;
                            end
                            else
                                state_next.point_phase = state.point_phase + 3'd1;
                        end
                    end
                end
                PH_EXPECT_TEXTURE:
                begin
                    if (c == CH_RPAREN)
                    begin
                        state_next.main_phase    = PH_TEXTURE;
                        state_next.token_started = 1'b0;
                    end
                    else
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                    end
                end
                PH_TEXTURE:
                begin
                    if (c == CH_SPACE)
                    begin
                        if (state.token_started)
                        begin
                            state_next.token_started = 1'b0;
                            state_next.main_phase    = PH_EXPECT_U;
                            ev.emit = 1'b1; ev.kind = EV_TEX_END;
                        end
                    end
                    else if (texture_char_ok(c))
                    begin
                        state_next.token_started = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_TEX_BYTE; ev.ch = c;
                    end
                    else
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_TEXTURE;
                    end
                end
                PH_EXPECT_U,
                PH_EXPECT_V:
                begin
                    if (c == CH_SPACE)
                    begin
                    end
                    else if (c == CH_LBRACK)
                    begin
                        state_next.main_phase    = (state.main_phase == PH_EXPECT_U) ? PH_U : PH_V;
                        state_next.axis_phase    = AX_X;
                        state_next.token_started = 1'b0;
                    end
                    else
                    begin
                        state_next.halted = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                    end
                end
                PH_U,
                PH_V:
                begin
                    if (c == CH_RBRACK)
                    begin
                        // closing bracket also ends a number still open
                        state_next.main_phase    = (state.main_phase == PH_U) ?
                                                   PH_EXPECT_V : PH_ROTATION;
                        state_next.axis_phase    = AX_OUTSIDE;
                        state_next.token_started = 1'b0;
                        if (state.token_started && ax_in_group)
                        begin
                            ev.emit = 1'b1; ev.kind = EV_NUM_END; ev.field = ax_field;
                        end
                    end
                    else if (!ax_in_group)
                    begin
                        if (c != CH_SPACE)
                        begin
                            state_next.halted = 1'b1;
                            ev.emit = 1'b1; ev.kind = EV_ERROR; ev.err = ERR_UNEXPECTED;
                        end
                    end
                    else if (c == CH_SPACE)
                    begin
                        if (state.token_started)
                        begin
                            state_next.token_started = 1'b0;
                            state_next.axis_phase    = (state.axis_phase == AX_SHIFT) ?
                                                       AX_OUTSIDE : state.axis_phase + 3'd1;
                            ev.emit = 1'b1; ev.kind = EV_NUM_END; ev.field = ax_field;
                        end
                    end
                    else
                    begin
                        state_next.token_started = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_NUM_BYTE; ev.field = ax_field; ev.ch = c;
                    end
                end
                PH_ROTATION:
                begin
                    if (c == CH_SPACE)
                    begin
                        if (state.token_started)
                        begin
                            state_next.token_started       = 1'b0;
                            state_next.rotation_len        = 2'd0;
                            state_next.rotation_first_zero = 1'b0;
                            state_next.main_phase          = PH_USCALE;
                            ev.emit = 1'b1; ev.kind = EV_NUM_END; ev.field = FLD_ROTATION;
                            ev.rot_nonzero = !(state.rotation_len == 2'd1 &&
                                               state.rotation_first_zero);
                        end
                    end
                    else
                    begin
                        if (state.rotation_len == 2'd0)
                            state_next.rotation_first_zero = (c == CH_ZERO);
                        if (state.rotation_len < 2'd2)
                            state_next.rotation_len = state.rotation_len + 2'd1;
                        state_next.token_started = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_NUM_BYTE; ev.field = FLD_ROTATION; ev.ch = c;
                    end
                end
                PH_USCALE:
                begin
                    if (c == CH_SPACE)
                    begin
                        if (state.token_started)
                        begin
                            state_next.token_started = 1'b0;
                            state_next.main_phase    = PH_VSCALE;
                            ev.emit = 1'b1; ev.kind = EV_NUM_END; ev.field = FLD_USCALE;
                        end
                    end
                    else
                    begin
                        state_next.token_started = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_NUM_BYTE; ev.field = FLD_USCALE; ev.ch = c;
                    end
                end
                PH_VSCALE:
                begin
                    if (c == CH_SPACE || eol)
                    begin
                        if (state.token_started)
                        begin
                            state_next.token_started = 1'b0;
                            state_next.main_phase    = PH_BRUSH;
                            ev.emit = 1'b1; ev.kind = EV_NUM_END; ev.field = FLD_VSCALE;
                        end
                    end
                    else
                    begin
                        state_next.token_started = 1'b1;
                        ev.emit = 1'b1; ev.kind = EV_NUM_BYTE; ev.field = FLD_VSCALE; ev.ch = c;
                    end
                end
                default:
                begin
                    state_next = state;
                end
            endcase
        end
    end

endmodule

@@ design/bmtt_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmtt_out_reg
// Result register with valid/ready handshake; frees itself as it drains.
// ----------------------------------------------------------------------------
module bmtt_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  bmtt_pkg::token_event_t ev,
    input  logic                   out_ready,
    output logic                   space,
    output logic                   out_valid,
    output logic [3:0]             event_kind,
    output logic [4:0]             field_index,
    output logic [7:0]             char_out,
    output logic                   rotation_nonzero,
    output logic [1:0]             error_code
);
    import bmtt_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    token_event_t data_reg;

    // room when empty or the held result leaves this cycle
    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= ev;
    end

    assign out_valid        = valid_reg;
    assign event_kind       = data_reg.kind;
    assign field_index      = data_reg.field;
    assign char_out         = data_reg.ch;
    assign rotation_nonzero = data_reg.rot_nonzero;
    assign error_code       = data_reg.err;

endmodule

@@ design/brush_map_text_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brush_map_text_tokenizer
// Byte-at-a-time tokenizer for brush-map text: entities, key/value pairs,
// brushes and planes, emitted as tagged events.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | data_byte
//  out     | out_valid / out_ready| event_kind, field_index, char_out,
//          |                      | rotation_nonzero, error_code
//
//  One byte per cycle while in_ready is high: the parser state update is a
//  single combinational step between the state register and the result register.
//  A byte that yields an event shows it on out the cycle after its transfer.
//  in_ready drops only while a held result is not taken (out_valid && !out_ready).
//  Reset clears the parser state and the result valid; no clearing pass.
//  After an error event every later byte is consumed silently until reset.
// ----------------------------------------------------------------------------
module brush_map_text_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] event_kind,
    output logic [4:0] field_index,
    output logic [7:0] char_out,
    output logic       rotation_nonzero,
    output logic [1:0] error_code
);
    import bmtt_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    token_event_t step_ev;
    logic         in_xfer;
    logic         space;

    // Input is ready whenever the result register can take a result
    assign in_ready = space;
    assign in_xfer  = in_valid && in_ready;

    // Combinational grammar step for the current byte
    bmtt_step u_step (
        .state      (state_reg),
        .c          (data_byte),
        .state_next (state_next),
        .ev         (step_ev)
    );

    // Parser state advances only on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.main_phase          <= PH_OUT_ENTITY;
            state_reg.point_phase         <= PT_OUTSIDE;
            state_reg.coord_phase         <= CO_OUTSIDE;
            state_reg.axis_phase          <= AX_OUTSIDE;
            state_reg.token_started       <= 1'b0;
            state_reg.rotation_len        <= 2'd0;
            state_reg.rotation_first_zero <= 1'b0;
            state_reg.halted              <= 1'b0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result register; bytes with no event leave it untouched
    bmtt_out_reg u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (in_xfer && step_ev.emit),
        .ev               (step_ev),
        .out_ready        (out_ready),
        .space            (space),
        .out_valid        (out_valid),
        .event_kind       (event_kind),
        .field_index      (field_index),
        .char_out         (char_out),
        .rotation_nonzero (rotation_nonzero),
        .error_code       (error_code)
    );

    // Entering the halted state always comes with an error event on out
    a_halt_reports_error: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.halted) |-> out_valid && event_kind == EV_ERROR)
        else $error("halt without error event");

    // Once halted, the step logic produces no events and no state change
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.halted |-> !step_ev.emit && state_next == state_reg)
        else $error("event produced while halted");

    // Field index is only carried by number events
    a_field_only_numbers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_index != 5'd0 |->
            event_kind == EV_NUM_BYTE || event_kind == EV_NUM_END)
        else $error("field index on non-number event");

    // Rotation flag only on the end of the rotation field
    a_rotation_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rotation_nonzero |->
            event_kind == EV_NUM_END && field_index == FLD_ROTATION)
        else $error("rotation flag on wrong event");

endmodule
